[sv/poll_driven_command_queue_unit_defines.svh]
// assertion macros for the poll-driven command queue unit
// no dependencies; included by files that carry concurrent checks
`ifndef POLL_DRIVEN_COMMAND_QUEUE_UNIT_DEFINES_SVH
`define POLL_DRIVEN_COMMAND_QUEUE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent true implies consequent in the same cycle
`define PDCQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pdcq check failed");

// antecedent true implies consequent in the next cycle
`define PDCQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pdcq check failed");

`else

`define PDCQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PDCQ_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

[sv/pdcq_pkg.sv]
// shared types, codes and constants of the poll-driven command queue
// no dependencies
`timescale 1ns / 1ps

package pdcq_pkg;

	localparam int DEF_QUEUE_DEPTH = 20;
	localparam int DEF_ENTRY_BYTES = 20;
	localparam int CFG_W           = 5;
	localparam int CMD_FIFO_DEPTH  = 2;

	localparam logic [CFG_W-1:0] LONG_MIN_RESET  = 5'd19;
	localparam logic [CFG_W-1:0] SHORT_MAX_RESET = 5'd2;

	localparam logic [7:0] POLL_LONG  = 8'h73;
	localparam logic [7:0] POLL_SHORT = 8'h53;
	localparam logic [7:0] READY_0    = 8'h3f;
	localparam logic [7:0] READY_1    = 8'h20;

	// input mode codes
	localparam logic [1:0] MODE_PUSH = 2'd0;
	localparam logic [1:0] MODE_POLL = 2'd1;
	localparam logic [1:0] MODE_ACK  = 2'd2;

	// register indexes
	localparam logic REG_LONG_MIN  = 1'b0;
	localparam logic REG_SHORT_MAX = 1'b1;

	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_POLL = 2'd1,
		OP_ACK  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		KIND_REPLY        = 3'd0,
		KIND_QUEUED       = 3'd1,
		KIND_OVERFLOW     = 3'd2,
		KIND_TRUNC        = 3'd3,
		KIND_REMOVED      = 3'd4,
		KIND_NONE_REMOVED = 3'd5
	} kind_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] data_byte;
		logic       entry_end;
	} cmd_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] reply_byte;
		logic       reply_end;
		logic       from_queue;
	} res_t;

	// classified item handed from front to back
	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic       last;
	} op_item_t;

endpackage

[sv/pdcq_ram.sv]
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps

module pdcq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

[sv/pdcq_front.sv]
// front end: takes items, classifies the mode and queues them for the back end
// depends on pdcq_pkg
`timescale 1ns / 1ps

module pdcq_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  pdcq_pkg::cmd_t     cmd,
	output logic               busy,
	output pdcq_pkg::op_item_t item,
	output logic               item_valid,
	input  logic               item_pop
);

	import pdcq_pkg::*;

	localparam int PTR_W = $clog2(CMD_FIFO_DEPTH);
	localparam int LVL_W = $clog2(CMD_FIFO_DEPTH + 1);

	op_item_t         fifo_q [CMD_FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] level_q;
	op_item_t         cls;
	logic             cls_ok;
	logic             push;

	always_comb begin
		cls.data = cmd.data_byte;
		cls.last = cmd.entry_end;
		cls.op   = OP_PUSH;
		cls_ok   = 1'b1;
		case (cmd.mode)
			MODE_PUSH: cls.op = OP_PUSH;
			MODE_POLL: cls.op = OP_POLL;
			MODE_ACK:  cls.op = OP_ACK;
			// unused mode is dropped here
			default:   cls_ok = 1'b0;
		endcase
	end

	assign busy       = (level_q == LVL_W'(CMD_FIFO_DEPTH));
	assign push       = start && !busy && cls_ok;
	assign item_valid = (level_q != '0);
	assign item       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (item_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !item_pop) begin
				level_q <= level_q + LVL_W'(1);
			end else if (!push && item_pop) begin
				level_q <= level_q - LVL_W'(1);
			end
		end
	end

endmodule

[sv/pdcq_back.sv]
// back end: entry ring, length table and poll reply sequencer
// depends on pdcq_pkg and pdcq_ram
`timescale 1ns / 1ps

module pdcq_back #(
	parameter int QUEUE_DEPTH = pdcq_pkg::DEF_QUEUE_DEPTH,
	parameter int ENTRY_BYTES = pdcq_pkg::DEF_ENTRY_BYTES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pdcq_pkg::op_item_t           item,
	input  logic                         item_valid,
	output logic                         item_pop,
	input  logic [pdcq_pkg::CFG_W-1:0]   long_min,
	input  logic [pdcq_pkg::CFG_W-1:0]   short_max,
	output logic                         res_strobe,
	output pdcq_pkg::res_t               res
);

	import pdcq_pkg::*;

	localparam int SLOT_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int POS_W  = $clog2(ENTRY_BYTES + 1);
	localparam int ADDR_W = $clog2(QUEUE_DEPTH * ENTRY_BYTES);
	localparam int CMP_W  = (POS_W > CFG_W) ? POS_W : CFG_W;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_PUSH2  = 5'b00010,
		ST_LEN    = 5'b00100,
		ST_STREAM = 5'b01000,
		ST_FRAME2 = 5'b10000
	} state_t;

	state_t            state_q;
	logic [SLOT_W-1:0] head_q;
	logic [CNT_W-1:0]  count_q;
	logic [POS_W-1:0]  fill_q;
	logic              dropping_q;
	logic              last_queued_q;
	logic [7:0]        type_q;
	logic [POS_W-1:0]  len_q;
	logic [POS_W-1:0]  idx_q;
	logic [7:0]        frame2_q;
	logic              res_strobe_q;
	res_t              res_q;

	logic [CNT_W:0]    tail_sum;
	logic [CNT_W:0]    tail_wrap;
	logic [SLOT_W-1:0] tail_slot;
	logic [ADDR_W-1:0] head_base;
	logic [ADDR_W-1:0] tail_base;
	logic [POS_W-1:0]  rd_pos;
	logic [POS_W-1:0]  idx_next;

	logic              drop;
	logic              room;
	logic [POS_W-1:0]  new_fill;
	logic              do_push;
	logic              data_we;
	logic              len_we;
	logic [7:0]        data_rd;
	logic [POS_W-1:0]  len_rd;
	logic              has_entry;
	logic              long_ok;
	logic              short_ok;

	assign item_pop = (state_q == ST_IDLE) && item_valid;

	// tail slot: head plus count, folded once into the ring
	assign tail_sum  = (CNT_W+1)'(head_q) + (CNT_W+1)'(count_q);
	assign tail_wrap = (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH))
		? tail_sum - (CNT_W+1)'(QUEUE_DEPTH) : tail_sum;
	assign tail_slot = tail_wrap[SLOT_W-1:0];

	assign head_base = ADDR_W'(head_q) * ADDR_W'(ENTRY_BYTES);
	assign tail_base = ADDR_W'(tail_slot) * ADDR_W'(ENTRY_BYTES);

	assign drop     = dropping_q || ((fill_q == '0) && (count_q == CNT_W'(QUEUE_DEPTH)));
	assign room     = fill_q < POS_W'(ENTRY_BYTES);
	assign new_fill = room ? fill_q + POS_W'(1) : fill_q;
	assign do_push  = item_pop && (item.op == OP_PUSH) && !drop;
	assign data_we  = do_push && room;
	assign len_we   = do_push && item.last;

	// read one byte ahead of the one being sent
	assign idx_next = idx_q + POS_W'(1);
	assign rd_pos   = (state_q == ST_STREAM && idx_next < len_q) ? idx_next : '0;

	assign has_entry = (count_q != '0);
	assign long_ok   = (CMP_W'(len_rd) >= CMP_W'(long_min));
	assign short_ok  = (CMP_W'(len_rd) <= CMP_W'(short_max));

	pdcq_ram #(
		.WIDTH (8),
		.DEPTH (QUEUE_DEPTH * ENTRY_BYTES)
	) u_entry_ram (
		.clk     (clk),
		.wr_en   (data_we),
		.wr_addr (tail_base + ADDR_W'(fill_q)),
		.wr_data (item.data),
		.rd_addr (head_base + ADDR_W'(rd_pos)),
		.rd_data (data_rd)
	);

	pdcq_ram #(
		.WIDTH (POS_W),
		.DEPTH (QUEUE_DEPTH)
	) u_len_ram (
		.clk     (clk),
		.wr_en   (len_we),
		.wr_addr (tail_slot),
		.wr_data (new_fill),
		.rd_addr (head_q),
		.rd_data (len_rd)
	);

	always_ff @(posedge clk) begin
		if (item_pop && item.op == OP_POLL) begin
			type_q <= item.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			head_q        <= '0;
			count_q       <= '0;
			fill_q        <= '0;
			dropping_q    <= 1'b0;
			last_queued_q <= 1'b0;
			len_q         <= '0;
			idx_q         <= '0;
			frame2_q      <= '0;
			res_strobe_q  <= 1'b0;
			res_q         <= '0;
		end else begin
			res_strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (item_pop) begin
						case (item.op)
							OP_PUSH: begin
								if (drop) begin
									if (item.last) begin
										dropping_q   <= 1'b0;
										fill_q       <= '0;
										res_strobe_q <= 1'b1;
										res_q        <= '{KIND_OVERFLOW, 8'h00, 1'b1, 1'b0};
									end else begin
										dropping_q <= 1'b1;
									end
								end else begin
									if (item.last) begin
										count_q <= count_q + CNT_W'(1);
										fill_q  <= '0;
									end else begin
										fill_q <= new_fill;
									end
									if (!room) begin
										res_strobe_q <= 1'b1;
										res_q        <= '{KIND_TRUNC, 8'h00, !item.last, 1'b0};
										if (item.last) begin
											state_q <= ST_PUSH2;
										end
									end else if (item.last) begin
										res_strobe_q <= 1'b1;
										res_q        <= '{KIND_QUEUED, 8'h00, 1'b1, 1'b0};
									end
								end
							end
							OP_POLL: begin
								last_queued_q <= 1'b0;
								state_q       <= ST_LEN;
							end
							OP_ACK: begin
								res_strobe_q <= 1'b1;
								if (has_entry && last_queued_q) begin
									head_q <= (head_q == SLOT_W'(QUEUE_DEPTH - 1))
										? '0 : head_q + SLOT_W'(1);
									count_q <= count_q - CNT_W'(1);
									res_q   <= '{KIND_REMOVED, 8'h00, 1'b1, 1'b0};
								end else begin
									res_q <= '{KIND_NONE_REMOVED, 8'h00, 1'b1, 1'b0};
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_PUSH2: begin
					res_strobe_q <= 1'b1;
					res_q        <= '{KIND_QUEUED, 8'h00, 1'b1, 1'b0};
					state_q      <= ST_IDLE;
				end
				ST_LEN: begin
					// head length is valid now; byte 0 read is issued this cycle
					if (has_entry && ((type_q == POLL_LONG && long_ok) ||
						(type_q == POLL_SHORT && short_ok))) begin
						last_queued_q <= 1'b1;
						len_q         <= len_rd;
						idx_q         <= '0;
						state_q       <= ST_STREAM;
					end else if (has_entry && type_q == POLL_SHORT) begin
						res_strobe_q <= 1'b1;
						res_q        <= '{KIND_REPLY, READY_0, 1'b0, 1'b0};
						frame2_q     <= READY_1;
						state_q      <= ST_FRAME2;
					end else begin
						res_strobe_q <= 1'b1;
						res_q        <= '{KIND_REPLY, type_q, 1'b0, 1'b0};
						frame2_q     <= 8'h00;
						state_q      <= ST_FRAME2;
					end
				end
				ST_STREAM: begin
					res_strobe_q <= 1'b1;
					res_q        <= '{KIND_REPLY, data_rd, (idx_next == len_q), 1'b1};
					idx_q        <= idx_next;
					if (idx_next == len_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FRAME2: begin
					res_strobe_q <= 1'b1;
					res_q        <= '{KIND_REPLY, frame2_q, 1'b1, 1'b0};
					state_q      <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_strobe = res_strobe_q;
	assign res        = res_q;

endmodule

[sv/poll_driven_command_queue_unit.sv]
// top level of the poll-driven command queue: register port, front end, back end
// depends on pdcq_pkg, pdcq_front, pdcq_back and the assertion macro header
`timescale 1ns / 1ps
`include "poll_driven_command_queue_unit_defines.svh"

// usage:
// an item is taken on a clock edge with start high and busy low; mode selects
// push of one command byte, a poll, or an acknowledge. unused mode is discarded.
// results leave on res with res_strobe high for one cycle each; the receiver
// must take every result, there is no back-pressure on this side.
// the front end holds up to two classified items; busy rises when both are held.
// the back end runs one item at a time: an acknowledge, and a push byte that
// closes an entry or does not fit, gives its result from the result register;
// a truncated closing byte is followed by the queued result in the next cycle.
// a poll first reads the head length from the length ram, then streams the
// reply of at most ENTRY_BYTES bytes at one byte per cycle from the entry ram,
// or answers with one of the two-byte frames.
// long_min_length (offset 0) and short_max_length (offset 4) are written over
// the apb port; the user must do so only while no item is in flight (not enforced).
// reset empties the queue and restores the registers to 19 and 2; the entry and
// length rams are not cleared, only written entries are ever read.
module poll_driven_command_queue_unit #(
	parameter int QUEUE_DEPTH = pdcq_pkg::DEF_QUEUE_DEPTH,
	parameter int ENTRY_BYTES = pdcq_pkg::DEF_ENTRY_BYTES
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  pdcq_pkg::cmd_t cmd,
	output logic           res_strobe,
	output pdcq_pkg::res_t res,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);

	import pdcq_pkg::*;

	logic [CFG_W-1:0] long_min_q;
	logic [CFG_W-1:0] short_max_q;
	logic             cfg_we;
	op_item_t         item;
	logic             item_valid;
	logic             item_pop;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_SHORT_MAX) ? 32'(short_max_q) : 32'(long_min_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_min_q  <= LONG_MIN_RESET;
			short_max_q <= SHORT_MAX_RESET;
		end else if (cfg_we) begin
			if (paddr[2] == REG_LONG_MIN) begin
				long_min_q <= pwdata[CFG_W-1:0];
			end else begin
				short_max_q <= pwdata[CFG_W-1:0];
			end
		end
	end

	pdcq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.cmd        (cmd),
		.busy       (busy),
		.item       (item),
		.item_valid (item_valid),
		.item_pop   (item_pop)
	);

	pdcq_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ENTRY_BYTES (ENTRY_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_valid (item_valid),
		.item_pop   (item_pop),
		.long_min   (long_min_q),
		.short_max  (short_max_q),
		.res_strobe (res_strobe),
		.res        (res)
	);

	// only reply bytes can come from the head entry
	`PDCQ_ASSERT_IMP(a_fromq_reply, clk, arst_n, res_strobe && res.from_queue, res.kind == KIND_REPLY)

	// a reply run is sent without gaps until its last byte
	`PDCQ_ASSERT_NXT(a_reply_run, clk, arst_n, res_strobe && res.kind == KIND_REPLY && !res.reply_end, res_strobe && res.kind == KIND_REPLY)

	// status results other than truncation always close their run
	`PDCQ_ASSERT_IMP(a_status_end, clk, arst_n, res_strobe && res.kind != KIND_REPLY && res.kind != KIND_TRUNC, res.reply_end)

	// an open truncation is followed by the queued result
	`PDCQ_ASSERT_NXT(a_trunc_queued, clk, arst_n, res_strobe && res.kind == KIND_TRUNC && !res.reply_end, res_strobe && res.kind == KIND_QUEUED)

endmodule
